@@ hdl/utctime_to_epoch_seconds_core_assert.svh @@
// ----------------------------------------------------------------------------
// UTCTime converter assertion macros
// Concurrent checks on clk, disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef UTCTIME_TO_EPOCH_SECONDS_CORE_ASSERT_SVH
`define UTCTIME_TO_EPOCH_SECONDS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`define UTE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define UTE_ASSERT_IMP(lbl, ante, cons)
`define UTE_ASSERT_NXT(lbl, ante, cons)
`define UTE_ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ hdl/ute_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTCTime converter package
// Job record, converter states, field limits and the month start table.
// ----------------------------------------------------------------------------
package ute_pkg;

  localparam logic [4:0] DigitsLen      = 5'd12;
  localparam logic [4:0] OffsetEnd      = 5'd16;
  localparam logic [4:0] PosMax         = 5'd31;
  localparam logic [6:0] YearPivot      = 7'd50;
  localparam logic [7:0] Century        = 8'd100;
  localparam logic [3:0] LastMonthIdx   = 4'd11;
  localparam int         DaysPerYear    = 365;
  localparam int         Days1900To1970 = 25508;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharZulu  = 8'h5A;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;

  localparam logic [2:0] FldYear   = 3'd0;
  localparam logic [2:0] FldMonth  = 3'd1;
  localparam logic [2:0] FldDay    = 3'd2;
  localparam logic [2:0] FldHour   = 3'd3;
  localparam logic [2:0] FldMinute = 3'd4;

  typedef struct packed {
    logic       ok;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } job_t;

  typedef enum logic [2:0] {
    CONV_IDLE,
    CONV_YEAR,
    CONV_DAYS,
    CONV_HOUR,
    CONV_MIN,
    CONV_SEC,
    CONV_LOAD
  } conv_state_t;

  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd306;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ute_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTCTime converter stream interfaces
// Character input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface ute_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface ute_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;
  logic        valid_res;

  modport source (output valid, output epoch_seconds, output valid_res, input ready);
  modport sink   (input valid, input epoch_seconds, input valid_res, output ready);
endinterface
`default_nettype wire

@@ hdl/ute_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTCTime character parser
// Takes one character per beat, checks format and field ranges, and pushes
// one conversion job on the last character.
// ----------------------------------------------------------------------------
`include "utctime_to_epoch_seconds_core_assert.svh"
module ute_front (
  input  wire logic     clk,
  input  wire logic     rst,
  ute_in_if.sink        in_ch,
  output ute_pkg::job_t job,
  output logic          push,
  input  wire logic     full
);

  logic [4:0] pos;
  logic [3:0] high_digit;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic       format_error;

  logic       acc;
  logic       is_digit;
  logic [3:0] dval;
  logic [6:0] fval;
  logic [2:0] fidx;
  logic       fld_wr;
  logic       err_hit;
  logic       complete;

  assign in_ch.ready = !full;
  assign acc         = in_ch.valid && !full;
  assign push        = acc && in_ch.last_char;

  assign is_digit = (in_ch.char_byte >= ute_pkg::CharZero) &&
                    (in_ch.char_byte <= ute_pkg::CharNine);
  assign dval     = 4'(in_ch.char_byte - ute_pkg::CharZero);
  assign fval     = 7'({3'b000, high_digit} * 7'd10) + {3'b000, dval};
  assign fidx     = pos[3:1];

  always_comb begin
    err_hit  = 1'b0;
    complete = 1'b0;
    fld_wr   = 1'b0;
    if (pos < ute_pkg::DigitsLen) begin
      if (!is_digit) begin
        err_hit = 1'b1;
      end else if (pos[0]) begin
        fld_wr = 1'b1;
        unique case (fidx)
          ute_pkg::FldYear:   err_hit = 1'b0;
          ute_pkg::FldMonth:  err_hit = (fval < 7'd1) || (fval > 7'd12);
          ute_pkg::FldDay:    err_hit = (fval < 7'd1) || (fval > 7'd31);
          ute_pkg::FldHour:   err_hit = fval > 7'd23;
          ute_pkg::FldMinute: err_hit = fval > 7'd59;
          default:            err_hit = fval > 7'd59;
        endcase
      end
    end else if (pos == ute_pkg::DigitsLen) begin
      if (in_ch.char_byte == ute_pkg::CharZulu) begin
        err_hit  = !in_ch.last_char;
        complete = in_ch.last_char;
      end else if (in_ch.char_byte == ute_pkg::CharPlus ||
                   in_ch.char_byte == ute_pkg::CharMinus) begin
        err_hit = in_ch.last_char;
      end else begin
        err_hit = 1'b1;
      end
    end else if (pos <= ute_pkg::OffsetEnd) begin
      if (pos == ute_pkg::OffsetEnd) begin
        err_hit  = !is_digit || !in_ch.last_char;
        complete = in_ch.last_char;
      end else begin
        err_hit = !is_digit;
      end
    end else begin
      err_hit = 1'b1;
    end
  end

  always_comb begin
    job.ok     = complete && !format_error && !err_hit;
    job.year   = year;
    job.month  = month;
    job.day    = day;
    job.hour   = hour;
    job.minute = minute;
    job.second = second;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos          <= '0;
      high_digit   <= '0;
      year         <= '0;
      month        <= '0;
      day          <= '0;
      hour         <= '0;
      minute       <= '0;
      second       <= '0;
      format_error <= 1'b0;
    end else if (acc) begin
      if (pos != ute_pkg::PosMax) begin
        pos <= pos + 5'd1;
      end
      format_error <= format_error | err_hit;
      if (pos < ute_pkg::DigitsLen && is_digit && !pos[0]) begin
        high_digit <= dval;
      end
      if (fld_wr) begin
        unique case (fidx)
          ute_pkg::FldYear:   year   <= fval;
          ute_pkg::FldMonth:  month  <= fval[3:0];
          ute_pkg::FldDay:    day    <= fval[4:0];
          ute_pkg::FldHour:   hour   <= fval[4:0];
          ute_pkg::FldMinute: minute <= fval[5:0];
          default:            second <= fval[5:0];
        endcase
      end
    end
  end

  `UTE_ASSERT_NXT(a_front_restart, push, pos == 5'd0 && !format_error)
  `UTE_ASSERT_IMP(a_front_ok_end, push && job.ok, pos == ute_pkg::DigitsLen || pos == ute_pkg::OffsetEnd)

endmodule
`default_nettype wire

@@ hdl/ute_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTCTime job queue
// Short register queue between the parser and the converter.
// ----------------------------------------------------------------------------
`include "utctime_to_epoch_seconds_core_assert.svh"
module ute_fifo #(
  parameter int Depth = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ute_pkg::job_t  wdata,
  output logic                full,
  input  wire logic           pop,
  output ute_pkg::job_t       rdata,
  output logic                empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ute_pkg::job_t   mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = count == CntFull;
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  `UTE_ASSERT_NEVER(a_fifo_overflow, push && full)
  `UTE_ASSERT_NEVER(a_fifo_underflow, pop && empty)
  `UTE_ASSERT_NEVER(a_fifo_count, count > CntFull)

endmodule
`default_nettype wire

@@ hdl/ute_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTCTime epoch converter
// Turns a job into seconds since 1970 with at most one constant multiply per step
// and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "utctime_to_epoch_seconds_core_assert.svh"
module ute_conv (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ute_pkg::job_t  job,
  input  wire logic           empty,
  output logic                pop,
  ute_out_if.source           out_ch
);

  ute_pkg::conv_state_t state;
  ute_pkg::conv_state_t state_next;

  ute_pkg::job_t      cur;
  logic signed [33:0] acc;
  logic [31:0]        epoch;
  logic               res_ok;
  logic               out_valid;

  logic [7:0]         year_full;
  logic [7:0]         year_adj;
  logic [3:0]         mon_raw;
  logic [3:0]         mon;
  logic               load;

  assign out_ch.valid         = out_valid;
  assign out_ch.epoch_seconds = epoch;
  assign out_ch.valid_res     = res_ok;

  always_comb begin
    year_full = (cur.year <= ute_pkg::YearPivot) ? {1'b0, cur.year} + ute_pkg::Century
                                                 : {1'b0, cur.year};
    mon_raw   = cur.month - 4'd1;
    mon       = (mon_raw > ute_pkg::LastMonthIdx) ? 4'd0 : mon_raw;
    year_adj  = (mon < 4'd2) ? year_full - 8'd1 : year_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ute_pkg::CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    unique case (state)
      ute_pkg::CONV_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = ute_pkg::CONV_YEAR;
        end
      end
      ute_pkg::CONV_YEAR: state_next = ute_pkg::CONV_DAYS;
      ute_pkg::CONV_DAYS: state_next = ute_pkg::CONV_HOUR;
      ute_pkg::CONV_HOUR: state_next = ute_pkg::CONV_MIN;
      ute_pkg::CONV_MIN:  state_next = ute_pkg::CONV_SEC;
      ute_pkg::CONV_SEC:  state_next = ute_pkg::CONV_LOAD;
      ute_pkg::CONV_LOAD: begin
        if (!out_valid || out_ch.ready) begin
          load       = 1'b1;
          state_next = ute_pkg::CONV_IDLE;
        end
      end
      default: state_next = ute_pkg::CONV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end
    unique case (state)
      ute_pkg::CONV_YEAR: begin
        acc <= $signed(34'(year_adj)) * $signed(34'(ute_pkg::DaysPerYear));
      end
      ute_pkg::CONV_DAYS: begin
        acc <= acc + $signed(34'(year_adj >> 2))
                   + $signed(34'(ute_pkg::month_start(mon)))
                   + $signed(34'(cur.day)) - 34'sd1
                   - $signed(34'(ute_pkg::Days1900To1970));
      end
      ute_pkg::CONV_HOUR: acc <= acc * 34'sd24 + $signed(34'(cur.hour));
      ute_pkg::CONV_MIN:  acc <= acc * 34'sd60 + $signed(34'(cur.minute));
      ute_pkg::CONV_SEC:  acc <= acc * 34'sd60 + $signed(34'(cur.second));
      default:            acc <= acc;
    endcase
    if (load) begin
      epoch  <= (cur.ok && !acc[33]) ? acc[31:0] : 32'd0;
      res_ok <= cur.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  `UTE_ASSERT_IMP(a_conv_bad_zero, out_valid && !res_ok, epoch == 32'd0)
  `UTE_ASSERT_NXT(a_conv_start, pop, state == ute_pkg::CONV_YEAR)
  `UTE_ASSERT_IMP(a_conv_pop_idle, pop, state == ute_pkg::CONV_IDLE && out_valid == out_valid)

endmodule
`default_nettype wire

@@ hdl/utctime_to_epoch_seconds_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Result path: a free converter pops the queue after the last character is taken, then
//   runs year, days, hour, minute, second and load; load waits while the output stalls.
// Throughput: one character per cycle while the job queue is not full; the converter
//   takes one string at a time and the queue absorbs strings that end while it is busy.
// Reset: synchronous rst clears the parser, the queue and the output valid.
// ----------------------------------------------------------------------------
// UTCTime to epoch seconds core
// Parses an ASN.1 UTCTime string and returns seconds since 1970 with a
// validity flag, one result per string.
// ----------------------------------------------------------------------------
module utctime_to_epoch_seconds_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  ute_in_if.sink    in_ch,
  ute_out_if.source out_ch
);

  ute_pkg::job_t push_job;
  ute_pkg::job_t pop_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  ute_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .job   (push_job),
    .push  (push),
    .full  (full)
  );

  ute_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .full  (full),
    .pop   (pop),
    .rdata (pop_job),
    .empty (empty)
  );

  ute_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .job    (pop_job),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

@@ sim/utctime_to_epoch_seconds_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime to epoch seconds core testbench
// Streams UTCTime strings byte by byte into the core: epoch bounds, field
// limits, malformed strings, then random well-formed and corrupted strings.
// A local parser tracks every accepted byte and queues the expected result.
// Each result beat is compared field by field against that queue.
// ----------------------------------------------------------------------------
module utctime_to_epoch_seconds_core_tb;

  typedef struct {
    logic [31:0] secs;
    logic        ok;
  } epoch_result_t;

  logic clk;
  logic rst;
  logic calm;
  int   items_sent;
  int   mismatches;

  ute_in_if  in_ch();
  ute_out_if out_ch();

  utctime_to_epoch_seconds_core DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // parser state
  logic [4:0] pos;
  logic [3:0] tens;
  logic [6:0] yy;
  logic [3:0] mon;
  logic [4:0] dom;
  logic [4:0] hh;
  logic [5:0] mi;
  logic [5:0] ss;
  logic       bad;

  epoch_result_t expected_epochs[$];
  logic [7:0]    line_q[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic is_num(input logic [7:0] c);
    return c >= ute_pkg::CharZero && c <= ute_pkg::CharNine;
  endfunction

  task automatic utc_clear();
    pos  = '0;
    tens = '0;
    yy   = '0;
    mon  = '0;
    dom  = '0;
    hh   = '0;
    mi   = '0;
    ss   = '0;
    bad  = 1'b0;
  endtask

  function automatic logic [31:0] utc_to_seconds();
    longint y;
    longint days;
    longint cen;
    int     m;
    int     start;
    cen = longint'(ute_pkg::Century);
    y = longint'(yy);
    if (y <= longint'(ute_pkg::YearPivot)) y += cen;
    m = (mon == 4'd0 || mon > 4'd12) ? 0 : int'(mon) - 1;
    if (m < 2) y -= 1;
    case (m)
      0:       start = 306;
      1:       start = 337;
      2:       start = 0;
      3:       start = 31;
      4:       start = 61;
      5:       start = 92;
      6:       start = 122;
      7:       start = 153;
      8:       start = 184;
      9:       start = 214;
      10:      start = 245;
      default: start = 275;
    endcase
    days = y * longint'(ute_pkg::DaysPerYear) + y / 4 - y / cen + (y / cen + 3) / 4;
    days += longint'(start) + longint'(dom) - 1;
    days -= longint'(ute_pkg::Days1900To1970);
    days = ((days * 24 + longint'(hh)) * 60 + longint'(mi)) * 60 + longint'(ss);
    if (days < 0) return 32'd0;
    return days[31:0];
  endfunction

  task automatic utc_parse_step(input logic [7:0] c, input logic l);
    int            v;
    logic          done;
    epoch_result_t r;
    done = 1'b0;
    if (pos < ute_pkg::DigitsLen) begin
      if (!is_num(c)) begin
        bad = 1'b1;
      end else if (!pos[0]) begin
        tens = 4'(int'(c) - int'(ute_pkg::CharZero));
      end else begin
        v = int'(tens) * 10 + int'(c) - int'(ute_pkg::CharZero);
        case (pos[3:1])
          ute_pkg::FldYear: yy = 7'(v);
          ute_pkg::FldMonth: begin
            if (v < 1 || v > 12) bad = 1'b1;
            mon = 4'(v);
          end
          ute_pkg::FldDay: begin
            if (v < 1 || v > 31) bad = 1'b1;
            dom = 5'(v);
          end
          ute_pkg::FldHour: begin
            if (v > 23) bad = 1'b1;
            hh = 5'(v);
          end
          ute_pkg::FldMinute: begin
            if (v > 59) bad = 1'b1;
            mi = 6'(v);
          end
          default: begin
            if (v > 59) bad = 1'b1;
            ss = 6'(v);
          end
        endcase
      end
    end else if (pos == ute_pkg::DigitsLen) begin
      if (c == ute_pkg::CharZulu) begin
        if (!l) bad = 1'b1;
        else done = 1'b1;
      end else if (c == ute_pkg::CharPlus || c == ute_pkg::CharMinus) begin
        if (l) bad = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end else if (pos <= ute_pkg::OffsetEnd) begin
      if (!is_num(c)) bad = 1'b1;
      if (pos == ute_pkg::OffsetEnd) begin
        if (!l) bad = 1'b1;
        else done = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end
    if (pos != ute_pkg::PosMax) pos = pos + 5'd1;
    if (l) begin
      r.ok   = done && !bad;
      r.secs = r.ok ? utc_to_seconds() : 32'd0;
      expected_epochs.push_back(r);
      utc_clear();
    end
  endtask

  // result side: random stall bursts, none once calm
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    epoch_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_epochs.size() == 0) begin
        $error("unexpected result beat: epoch_seconds %0d valid_res %0b",
               out_ch.epoch_seconds, out_ch.valid_res);
        mismatches++;
      end else begin
        e = expected_epochs.pop_front();
        if (out_ch.epoch_seconds !== e.secs) begin
          $error("epoch_seconds: expected %0d, got %0d", e.secs, out_ch.epoch_seconds);
          mismatches++;
        end
        if (out_ch.valid_res !== e.ok) begin
          $error("valid_res: expected %0b, got %0b", e.ok, out_ch.valid_res);
          mismatches++;
        end
      end
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic l);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= c;
    in_ch.last_char <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    utc_parse_step(c, l);
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      send_beat(line_q[i], i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_two(input int v);
    line_q.push_back(ute_pkg::CharZero + 8'(v / 10));
    line_q.push_back(ute_pkg::CharZero + 8'(v % 10));
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_line();
  endtask

  task automatic build_random_time();
    int  k;
    int  n;
    logic [7:0] sign;
    push_two($urandom_range(0, 99));
    push_two($urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 12));
    push_two($urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(1, 31));
    push_two($urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 23));
    push_two($urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59));
    push_two($urandom_range(0, 9) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59));
    k = $urandom_range(0, 2);
    if (k == 0) begin
      line_q.push_back(ute_pkg::CharZulu);
    end else begin
      sign = (k == 1) ? ute_pkg::CharPlus : ute_pkg::CharMinus;
      line_q.push_back(sign);
      repeat (4) line_q.push_back(ute_pkg::CharZero + 8'($urandom_range(0, 9)));
    end
    // corrupt some of them
    case ($urandom_range(0, 9))
      0: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        n = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > n) void'(line_q.pop_back());
      end
      2: repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      3: line_q[ute_pkg::DigitsLen] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endtask

  task automatic test_epoch_bounds();
    send_text("700101000000Z");
    send_text("691231235959Z");
    send_text("000101000000Z");
    send_text("501231235959Z");
    send_text("510101000000Z");
    send_text("991231235959+0130");
    send_text("000229120000-2359");
    send_text("380119031408Z");
    send_text("000228235959Z");
    send_text("000301000000Z");
  endtask

  task automatic test_field_limits();
    send_text("001301000000Z");
    send_text("000001000000Z");
    send_text("000100000000Z");
    send_text("000132000000Z");
    send_text("000131240000Z");
    send_text("000131236000Z");
    send_text("000131235960Z");
    send_text("999999999999Z");
    send_text("001231235959Z");
  endtask

  task automatic test_format_errors();
    send_text("0001010000A0Z");
    send_text("/00101000000Z");
    send_text("00010100000:Z");
    send_text("000101000000Z0");
    send_text("000101000000+");
    send_text("000101000000+01x0");
    send_text("000101000000+01000");
    send_text("00010100");
    send_text("000101000000Q");
    send_text("Z");
    push_text("00010100000");
    line_q.push_back(ute_pkg::CharZero | 8'h80);
    line_q.push_back(ute_pkg::CharZulu);
    send_line();
    // run the position counter into saturation
    repeat (40) line_q.push_back(ute_pkg::CharZero + 8'($urandom_range(0, 9)));
    send_line();
  endtask

  task automatic test_random_strings(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_random_time();
      end
      send_line();
    end
  endtask

  task automatic test_back_to_back(input int upto);
    calm = 1'b1;
    test_random_strings(upto);
  endtask

  initial begin
    rst             = 1'b1;
    calm            = 1'b0;
    items_sent      = 0;
    mismatches      = 0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = 8'h00;
    in_ch.last_char = 1'b0;
    utc_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_epoch_bounds();
    test_field_limits();
    test_format_errors();
    test_random_strings(1500);
    test_back_to_back(1800);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
